/* rtl/core/square_wave_sound_channel_macros.svh */
// Assertion helpers shared by the square wave channel RTL.
`ifndef SQUARE_WAVE_SOUND_CHANNEL_MACROS_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define SQW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true on a clock edge.
`define SQW_ASSERT_NEVER(label, cond, msg) \
  `SQW_ASSERT(label, !(cond), msg)

`endif

/* rtl/core/sqw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_pkg
// Types, codes and helper functions of the square wave sound channel.
// ----------------------------------------------------------------------------
package sqw_pkg;

  typedef enum logic [2:0] {
    OP_WRITE        = 3'd0,
    OP_READ         = 3'd1,
    OP_TIMER_TICK   = 3'd2,
    OP_LENGTH_TICK  = 3'd3,
    OP_ENV_TICK     = 3'd4,
    OP_SWEEP_TICK   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    REG_SWEEP  = 3'd0,
    REG_DUTY   = 3'd1,
    REG_ENV    = 3'd2,
    REG_FREQ_L = 3'd3,
    REG_FREQ_H = 3'd4
  } reg_e;

  localparam logic [15:0] BaseReset   = 16'hFF10;
  localparam logic [15:0] LastOffset  = 16'd4;
  localparam logic [13:0] TimerReset  = 14'd64;
  localparam logic [6:0]  LengthFull  = 7'd64;
  localparam logic [3:0]  VolMax      = 4'd15;
  localparam logic [7:0]  ReadOpen    = 8'hFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] level;
    logic       running;
  } result_t;

  typedef struct packed {
    logic [2:0]  sweep_load;
    logic        sweep_down;
    logic [2:0]  sweep_amount;
    logic [1:0]  duty_select;
    logic [6:0]  length_left;
    logic [3:0]  start_volume;
    logic        envelope_up;
    logic [2:0]  envelope_load;
    logic        dac_on;
    logic [10:0] frequency;
    logic        length_enable;
    logic        channel_on;
    logic        envelope_active;
    logic        sweep_active;
    logic [10:0] sweep_shadow;
    logic        wave_bit;
    logic [3:0]  out_level;
    logic [13:0] period_timer;
    logic [2:0]  duty_step;
    logic [3:0]  volume_now;
    logic [3:0]  envelope_count;
    logic [3:0]  sweep_count;
  } state_t;

  // Power-on state: everything clear but the period timer.
  function automatic state_t reset_state();
    state_t s;
    s              = '0;
    s.period_timer = TimerReset;
    return s;
  endfunction

  // A load of zero counts as eight.
  function automatic logic [3:0] reload_of(logic [2:0] load);
    return (load != 3'd0) ? {1'b0, load} : 4'd8;
  endfunction

  function automatic logic [13:0] timer_reload(logic [10:0] freq);
    logic [11:0] span;
    span = 12'd2048 - {1'b0, freq};
    return {span, 2'b00};
  endfunction

  // Next sweep frequency; bit 11 set means past the limit.
  function automatic logic [11:0] sweep_calc(logic [10:0] shadow, logic [2:0] amount,
                                              logic down);
    logic [11:0] delta;
    delta = {1'b0, shadow} >> amount;
    return down ? ({1'b0, shadow} - delta) : ({1'b0, shadow} + delta);
  endfunction

  function automatic logic duty_bit(logic [1:0] duty, logic [2:0] step);
    logic [7:0] shape;
    case (duty)
      2'd0:    shape = 8'b1111_1110;
      2'd1:    shape = 8'b1111_1100;
      2'd2:    shape = 8'b1111_0000;
      default: shape = 8'b1100_0000;
    endcase
    return shape[step];
  endfunction

endpackage

/* rtl/core/sqw_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqw_core
// Channel state and the single-pass update for one item.
// ----------------------------------------------------------------------------
`include "square_wave_sound_channel_macros.svh"

module sqw_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  sqw_pkg::item_t   item_i,
  input  logic [15:0]      base_i,
  output sqw_pkg::result_t result_o
);

  sqw_pkg::state_t st_q, st_d;
  logic [15:0] offset;
  logic        in_range;
  logic [7:0]  rd;
  logic [7:0]  wd;
  logic [11:0] f_first;
  logic [11:0] f_second;
  logic [3:0]  cnt_dec;
  logic [13:0] pt_dec;
  logic [2:0]  step_inc;

  assign offset   = item_i.address - base_i;
  assign in_range = (offset <= sqw_pkg::LastOffset);
  assign wd       = item_i.write_data;

  always_comb begin
    st_d     = st_q;
    rd       = 8'h00;
    f_first  = 12'd0;
    f_second = 12'd0;
    cnt_dec  = 4'd0;
    pt_dec   = 14'd0;
    step_inc = 3'd0;
    unique case (sqw_pkg::op_e'(item_i.op))
      sqw_pkg::OP_WRITE: begin
        if (in_range) begin
          unique case (sqw_pkg::reg_e'(offset[2:0]))
            sqw_pkg::REG_SWEEP: begin
              st_d.sweep_load   = wd[6:4];
              st_d.sweep_down   = wd[3];
              st_d.sweep_amount = wd[2:0];
            end
            sqw_pkg::REG_DUTY: begin
              st_d.duty_select = wd[7:6];
              st_d.length_left = sqw_pkg::LengthFull - {1'b0, wd[5:0]};
            end
            sqw_pkg::REG_ENV: begin
              st_d.start_volume  = wd[7:4];
              st_d.envelope_up   = wd[3];
              st_d.envelope_load = wd[2:0];
              st_d.dac_on        = (wd[7:3] != 5'd0);
              if (wd[7:3] == 5'd0) begin
                st_d.channel_on = 1'b0;
              end
            end
            sqw_pkg::REG_FREQ_L: begin
              st_d.frequency[7:0] = wd;
            end
            sqw_pkg::REG_FREQ_H: begin
              st_d.frequency[10:8] = wd[2:0];
              st_d.length_enable   = wd[6];
              if (wd[7]) begin
                // Restart the channel with the freshly written frequency.
                st_d.channel_on      = 1'b1;
                st_d.envelope_active = 1'b1;
                st_d.period_timer    = {st_q.period_timer[13:2], 2'b00} & 14'd0
                                       | {12'd0, st_q.period_timer[1:0]}
                                       | sqw_pkg::timer_reload(st_d.frequency);
                st_d.envelope_count  = sqw_pkg::reload_of(st_q.envelope_load);
                st_d.volume_now      = st_q.start_volume;
                if (st_q.length_left == 7'd0) begin
                  st_d.length_left = sqw_pkg::LengthFull;
                end
                st_d.sweep_shadow = st_d.frequency;
                st_d.sweep_count  = sqw_pkg::reload_of(st_q.sweep_load);
                st_d.sweep_active = 1'b1;
                if (st_q.sweep_amount != 3'd0) begin
                  f_first = sqw_pkg::sweep_calc(st_d.frequency, st_q.sweep_amount,
                                                st_q.sweep_down);
                  if (f_first[11]) begin
                    st_d.channel_on   = 1'b0;
                    st_d.sweep_active = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      sqw_pkg::OP_READ: begin
        rd = sqw_pkg::ReadOpen;
        if (in_range) begin
          unique case (sqw_pkg::reg_e'(offset[2:0]))
            sqw_pkg::REG_SWEEP:  rd = {1'b1, st_q.sweep_load, st_q.sweep_down,
                                       st_q.sweep_amount};
            sqw_pkg::REG_DUTY:   rd = {st_q.duty_select, 6'h3F};
            sqw_pkg::REG_ENV:    rd = {st_q.start_volume, st_q.envelope_up,
                                       st_q.envelope_load};
            sqw_pkg::REG_FREQ_H: rd = {1'b1, st_q.length_enable, 6'h3F};
            default:             rd = sqw_pkg::ReadOpen;
          endcase
        end
      end
      sqw_pkg::OP_TIMER_TICK: begin
        pt_dec = (st_q.period_timer != 14'd0) ? st_q.period_timer - 14'd1 : 14'd0;
        st_d.period_timer = pt_dec;
        if (pt_dec == 14'd0) begin
          step_inc          = st_q.duty_step + 3'd1;
          st_d.period_timer = sqw_pkg::timer_reload(st_q.frequency);
          st_d.duty_step    = step_inc;
          st_d.wave_bit     = sqw_pkg::duty_bit(st_q.duty_select, step_inc);
        end
        st_d.out_level = (st_q.channel_on && st_q.dac_on && st_d.wave_bit) ?
                         st_q.volume_now : 4'd0;
      end
      sqw_pkg::OP_LENGTH_TICK: begin
        if (st_q.length_enable && st_q.length_left != 7'd0) begin
          st_d.length_left = st_q.length_left - 7'd1;
          if (st_q.length_left == 7'd1) begin
            st_d.channel_on = 1'b0;
          end
        end
      end
      sqw_pkg::OP_ENV_TICK: begin
        // Envelope holds at silence and at full volume.
        if (st_q.volume_now != 4'd0 && st_q.volume_now != sqw_pkg::VolMax &&
            st_q.envelope_count != 4'd0) begin
          cnt_dec             = st_q.envelope_count - 4'd1;
          st_d.envelope_count = cnt_dec;
          if (cnt_dec == 4'd0) begin
            st_d.envelope_count = sqw_pkg::reload_of(st_q.envelope_load);
            if (st_q.envelope_active && st_q.envelope_load != 3'd0) begin
              if (st_q.envelope_up) begin
                st_d.volume_now = st_q.volume_now + 4'd1;
              end else begin
                st_d.volume_now = st_q.volume_now - 4'd1;
              end
            end
            if (st_d.volume_now == 4'd0 || st_d.volume_now == sqw_pkg::VolMax) begin
              st_d.envelope_active = 1'b0;
            end
          end
        end
      end
      sqw_pkg::OP_SWEEP_TICK: begin
        if (st_q.sweep_count != 4'd0) begin
          cnt_dec          = st_q.sweep_count - 4'd1;
          st_d.sweep_count = cnt_dec;
          if (cnt_dec == 4'd0) begin
            st_d.sweep_count  = sqw_pkg::reload_of(st_q.sweep_load);
            st_d.sweep_shadow = st_q.frequency;
            if (st_q.sweep_active && st_q.sweep_load != 3'd0) begin
              f_first = sqw_pkg::sweep_calc(st_q.frequency, st_q.sweep_amount,
                                            st_q.sweep_down);
              if (f_first[11]) begin
                st_d.channel_on   = 1'b0;
                st_d.sweep_active = 1'b0;
              end else if (st_q.sweep_amount != 3'd0) begin
                st_d.sweep_shadow = f_first[10:0];
                st_d.frequency    = f_first[10:0];
                st_d.period_timer = sqw_pkg::timer_reload(f_first[10:0]);
                // Look one step ahead: shut off now if the next step overflows.
                f_second = sqw_pkg::sweep_calc(f_first[10:0], st_q.sweep_amount,
                                               st_q.sweep_down);
                if (f_second[11]) begin
                  st_d.channel_on   = 1'b0;
                  st_d.sweep_active = 1'b0;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= sqw_pkg::reset_state();
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  assign result_o.read_data = rd;
  assign result_o.level     = st_d.out_level;
  assign result_o.running   = (st_d.length_left != 7'd0) && st_d.channel_on && st_d.dac_on;

  `SQW_ASSERT(a_length_bound, st_q.length_left <= sqw_pkg::LengthFull,
              "length counter above full length")
  `SQW_ASSERT(a_env_count_bound, st_q.envelope_count <= 4'd8,
              "envelope counter above its reload")
  `SQW_ASSERT(a_state_holds, !fire_i |=> $stable(st_q),
              "channel state changed without an item")

endmodule

/* rtl/core/square_wave_sound_channel.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_wave_sound_channel
// Square wave sound channel with sweep, length counter and volume envelope.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per op (bus write, bus read, timer, length, envelope or
//           sweep tick). Accepted when in_valid_i is high and in_stall_o low.
//   out_* : one result per item: read data, output level, running flag.
//           Taken when out_valid_o is high and out_stall_i low.
//   cfg_* : writes the bus base address; cfg_ready_o is always high. Write
//           it only while no item is in flight.
// Flow: an item lands in the input register, is processed against the
//   channel state once the result register is free or draining, and its
//   result is registered in the result register and shown on out_*.
//   Throughput is one item per cycle while no result is stalled; the state
//   update between the input and result registers is combinational.
// Reset: the channel state is zero, the period timer starts at 64 and the base
//   address at 0xFF10; no clearing pass is needed.
// Stall: a stalled result holds in the result register; the input register
//   keeps one more item and in_stall_o rises until the result is taken.
// ----------------------------------------------------------------------------
`include "square_wave_sound_channel_macros.svh"

module square_wave_sound_channel (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sqw_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sqw_pkg::result_t out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [15:0]      cfg_data_i
);

  logic             in_valid_q;
  sqw_pkg::item_t   in_item_q;
  logic             out_valid_q;
  sqw_pkg::result_t out_item_q;
  sqw_pkg::result_t result;
  logic [15:0]      base_q;
  logic             fire;
  logic             in_accept;

  // Advance the held item when the result register is free or draining.
  assign fire       = in_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= sqw_pkg::BaseReset;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

  sqw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .base_i   (base_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `SQW_ASSERT(a_fire_loads_result, fire |=> out_valid_q,
              "processed item left no result")
  `SQW_ASSERT(a_blocked_item_held, in_valid_q && out_valid_q && out_stall_i |=> in_valid_q,
              "item dropped while result stalled")
  `SQW_ASSERT_NEVER(a_fire_into_full, fire && out_valid_q && out_stall_i,
                    "result overwritten while stalled")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the square wave sound channel. A scoreboard class
// keeps its own copy of the channel registers, timers, envelope and sweep,
// predicts the result of every accepted item and checks the results in
// order. Stimulus: a short directed run, then random bus traffic and ticks
// under several base addresses, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import sqw_pkg::*;

  class sqw_scoreboard;
    state_t      ch;
    logic [15:0] base;
    result_t     awaited_results[$];
    int          mismatches;

    function new();
      ch = '0;
      ch.period_timer = 14'd64;
      base = 16'hFF10;
      mismatches = 0;
    endfunction

    function logic [3:0] reload_count(logic [2:0] load);
      return (load != 3'd0) ? {1'b0, load} : 4'd8;
    endfunction

    function logic [13:0] period_span();
      return (14'd2048 - 14'(ch.frequency)) << 2;
    endfunction

    // Compute the next sweep frequency; shut the channel off past the limit.
    function logic [11:0] sweep_step();
      logic [11:0] shift;
      logic [11:0] f;
      shift = {1'b0, ch.sweep_shadow} >> ch.sweep_amount;
      f = ch.sweep_down ? {1'b0, ch.sweep_shadow} - shift : {1'b0, ch.sweep_shadow} + shift;
      if (f > 12'd2047) begin
        ch.channel_on = 1'b0;
        ch.sweep_active = 1'b0;
      end
      return f;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void step_channel(item_t it);
      logic [15:0] off;
      logic [7:0]  d;
      logic [7:0]  rd;
      logic [7:0]  shape;
      logic [11:0] f;
      result_t     r;
      off = it.address - base;
      d = it.write_data;
      rd = 8'h00;
      case (op_e'(it.op))
        OP_WRITE: begin
          if (off <= LastOffset) begin
            case (reg_e'(off[2:0]))
              REG_SWEEP: begin
                ch.sweep_load = d[6:4];
                ch.sweep_down = d[3];
                ch.sweep_amount = d[2:0];
              end
              REG_DUTY: begin
                ch.duty_select = d[7:6];
                ch.length_left = 7'd64 - 7'(d[5:0]);
              end
              REG_ENV: begin
                ch.start_volume = d[7:4];
                ch.envelope_up = d[3];
                ch.envelope_load = d[2:0];
                ch.dac_on = |d[7:3];
                if (!ch.dac_on) ch.channel_on = 1'b0;
              end
              REG_FREQ_L: ch.frequency[7:0] = d;
              REG_FREQ_H: begin
                ch.frequency[10:8] = d[2:0];
                ch.length_enable = d[6];
                // restart the channel
                if (d[7]) begin
                  ch.channel_on = 1'b1;
                  ch.envelope_active = 1'b1;
                  ch.period_timer = (ch.period_timer & 14'd3) | period_span();
                  ch.envelope_count = reload_count(ch.envelope_load);
                  ch.volume_now = ch.start_volume;
                  if (ch.length_left == 7'd0) ch.length_left = 7'd64;
                  ch.sweep_shadow = ch.frequency;
                  ch.sweep_count = reload_count(ch.sweep_load);
                  ch.sweep_active = (ch.sweep_count != 4'd0) || (ch.sweep_amount != 3'd0);
                  if (ch.sweep_amount != 3'd0) void'(sweep_step());
                end
              end
              default: ;
            endcase
          end
        end
        OP_READ: begin
          rd = 8'hFF;
          if (off <= LastOffset) begin
            case (reg_e'(off[2:0]))
              REG_SWEEP: rd = {1'b1, ch.sweep_load, ch.sweep_down, ch.sweep_amount};
              REG_DUTY:  rd = {ch.duty_select, 6'h3F};
              REG_ENV:   rd = {ch.start_volume, ch.envelope_up, ch.envelope_load};
              REG_FREQ_H: rd = {1'b1, ch.length_enable, 6'h3F};
              default:   rd = 8'hFF;
            endcase
          end
        end
        OP_TIMER_TICK: begin
          if (ch.period_timer != 14'd0) ch.period_timer--;
          if (ch.period_timer == 14'd0) begin
            ch.period_timer = period_span();
            ch.duty_step++;
            case (ch.duty_select)
              2'd0:    shape = 8'hFE;
              2'd1:    shape = 8'hFC;
              2'd2:    shape = 8'hF0;
              default: shape = 8'hC0;
            endcase
            ch.wave_bit = shape[ch.duty_step];
          end
          ch.out_level = (ch.channel_on && ch.dac_on && ch.wave_bit) ? ch.volume_now : 4'd0;
        end
        OP_LENGTH_TICK: begin
          if (ch.length_enable && ch.length_left != 7'd0) begin
            ch.length_left--;
            if (ch.length_left == 7'd0) ch.channel_on = 1'b0;
          end
        end
        OP_ENV_TICK: begin
          // the envelope sits still at either end of the volume range
          if (ch.volume_now != 4'd0 && ch.volume_now != 4'd15 && ch.envelope_count != 4'd0) begin
            ch.envelope_count--;
            if (ch.envelope_count == 4'd0) begin
              ch.envelope_count = reload_count(ch.envelope_load);
              if (ch.envelope_active && ch.envelope_load != 3'd0) begin
                if (ch.envelope_up && ch.volume_now < 4'd15) ch.volume_now++;
                else if (!ch.envelope_up && ch.volume_now > 4'd0) ch.volume_now--;
              end
              if (ch.volume_now == 4'd0 || ch.volume_now == 4'd15) ch.envelope_active = 1'b0;
            end
          end
        end
        OP_SWEEP_TICK: begin
          if (ch.sweep_count != 4'd0) begin
            ch.sweep_count--;
            if (ch.sweep_count == 4'd0) begin
              ch.sweep_count = reload_count(ch.sweep_load);
              ch.sweep_shadow = ch.frequency;
              if (ch.sweep_active && ch.sweep_load != 3'd0) begin
                f = sweep_step();
                if (f <= 12'd2047 && ch.sweep_amount != 3'd0) begin
                  ch.sweep_shadow = f[10:0];
                  ch.frequency = f[10:0];
                  ch.period_timer = period_span();
                  void'(sweep_step());
                end
              end
            end
          end
        end
        default: ;
      endcase
      r.read_data = rd;
      r.level = ch.out_level;
      r.running = (ch.length_left != 7'd0) && ch.channel_on && ch.dac_on;
      awaited_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (awaited_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: read_data %02h level %0d running %0b",
                   got.read_data, got.level, got.running);
        mismatches++;
        return;
      end
      exp = awaited_results.pop_front();
      if (got.read_data !== exp.read_data || got.level !== exp.level ||
          got.running !== exp.running) begin
        if (mismatches < 10)
          $display("mismatch: expected read_data %02h level %0d running %0b, got %02h %0d %0b",
                   exp.read_data, exp.level, exp.running,
                   got.read_data, got.level, got.running);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  item_t       in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  result_t     out_item_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;

  sqw_scoreboard sb;
  logic [15:0]   cur_base;
  bit            no_gaps;

  square_wave_sound_channel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int draw_wait();
    return no_gaps ? 0 : int'($urandom_range(0, 4));
  endfunction

  function automatic item_t bus_item(op_e op, logic [15:0] off, logic [7:0] d);
    item_t it;
    it.op = op;
    it.address = cur_base + off;
    it.write_data = d;
    return it;
  endfunction

  // Valid stays high after acceptance; the next send or a drain decides.
  task automatic send_item(input item_t it);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.step_channel(it);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [15:0] v);
    wait_drain();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.base = v;
    cur_base = v;
  endtask

  // Result side: take results and, after each, raise a stall of random length, which may be none.
  initial begin
    int hold;
    hold = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) continue;
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_item_o);
        hold = draw_wait();
        out_stall_i <= (hold != 0);
      end else if (hold != 0) begin
        hold--;
        if (hold == 0) out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [15:0] phase_base [5];
    logic [15:0] off;
    logic [7:0]  d;
    op_e         op;
    int          sent;
    int          pick;
    bit          drained;
    sb = new();
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_item_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    no_gaps = 1'b0;
    cur_base = 16'hFF10;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of every register, an unused offset and a far address
    send_item(bus_item(OP_READ, 16'(REG_SWEEP), 8'h00));
    send_item(bus_item(OP_READ, 16'(REG_DUTY), 8'h00));
    send_item(bus_item(OP_READ, 16'(REG_ENV), 8'h00));
    send_item(bus_item(OP_READ, 16'(REG_FREQ_L), 8'h00));
    send_item(bus_item(OP_READ, 16'(REG_FREQ_H), 8'h00));
    send_item(bus_item(OP_READ, 16'd5, 8'h00));
    send_item(bus_item(OP_READ, 16'hFFFF, 8'h00));
    // trigger with the converter off: enabled but silent
    send_item(bus_item(OP_WRITE, 16'(REG_ENV), 8'h00));
    send_item(bus_item(OP_WRITE, 16'(REG_FREQ_L), 8'hFF));
    send_item(bus_item(OP_WRITE, 16'(REG_FREQ_H), 8'h87));
    send_item(bus_item(OP_TIMER_TICK, 16'h0000, 8'h00));
    // downward sweep at full shift, length of one, volume at the top
    send_item(bus_item(OP_WRITE, 16'(REG_SWEEP), 8'hFF));
    send_item(bus_item(OP_WRITE, 16'(REG_DUTY), 8'hFF));
    send_item(bus_item(OP_WRITE, 16'(REG_ENV), 8'hF0));
    send_item(bus_item(OP_WRITE, 16'(REG_FREQ_H), 8'hC7));
    send_item(bus_item(OP_ENV_TICK, 16'hFFFF, 8'hFF));
    send_item(bus_item(OP_TIMER_TICK, 16'hFFFF, 8'hFF));
    send_item(bus_item(OP_LENGTH_TICK, 16'hFFFF, 8'hFF));
    // upward sweep past the limit at trigger, volume at zero
    send_item(bus_item(OP_WRITE, 16'(REG_SWEEP), 8'h11));
    send_item(bus_item(OP_WRITE, 16'(REG_DUTY), 8'h00));
    send_item(bus_item(OP_WRITE, 16'(REG_ENV), 8'h08));
    send_item(bus_item(OP_WRITE, 16'(REG_FREQ_H), 8'h87));
    send_item(bus_item(OP_SWEEP_TICK, 16'h0000, 8'h00));
    send_item(bus_item(OP_ENV_TICK, 16'h0000, 8'h00));
    // write past the last register: dropped
    send_item(bus_item(OP_WRITE, 16'd5, 8'hAA));
    send_item(bus_item(OP_READ, 16'(REG_FREQ_H), 8'h00));

    phase_base[0] = 16'h0000;
    phase_base[1] = 16'hFFFF;
    phase_base[2] = 16'($urandom);
    phase_base[3] = 16'hFF10;
    phase_base[4] = 16'($urandom);
    foreach (phase_base[p]) begin
      write_base(phase_base[p]);
      sent = 0;
      drained = 1'b0;
      while (sent < 360) begin
        if ($urandom_range(0, 59) == 0) no_gaps = !no_gaps;
        // hold off until the channel has answered everything
        if (!drained && sent >= 180) begin
          wait_drain();
          drained = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          // full setup followed by a trigger
          send_item(bus_item(OP_WRITE, 16'(REG_SWEEP), 8'($urandom)));
          send_item(bus_item(OP_WRITE, 16'(REG_DUTY), 8'($urandom)));
          send_item(bus_item(OP_WRITE, 16'(REG_ENV), 8'($urandom)));
          d = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hF0, 8'hFF)) : 8'($urandom);
          send_item(bus_item(OP_WRITE, 16'(REG_FREQ_L), d));
          d = 8'($urandom);
          d[7] = 1'b1;
          if ($urandom_range(0, 2) != 0) d[2:0] = 3'd7;
          send_item(bus_item(OP_WRITE, 16'(REG_FREQ_H), d));
          sent += 5;
        end else begin
          if (pick < 40) op = OP_TIMER_TICK;
          else if (pick < 50) op = OP_LENGTH_TICK;
          else if (pick < 60) op = OP_ENV_TICK;
          else if (pick < 70) op = OP_SWEEP_TICK;
          else if (pick < 82) op = OP_READ;
          else op = OP_WRITE;
          off = ($urandom_range(0, 9) != 0) ? 16'($urandom_range(0, 5)) : 16'($urandom);
          d = 8'($urandom);
          if (op == OP_WRITE && off == 16'(REG_FREQ_H) && $urandom_range(0, 1) == 0)
            d[2:0] = 3'd7;
          if (op == OP_WRITE && off == 16'(REG_FREQ_L) && $urandom_range(0, 1) == 0)
            d[7:4] = 4'hF;
          send_item(bus_item(op, off, d));
          sent++;
        end
      end
    end

    no_gaps = 1'b0;
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** square_wave_sound_channel: PASSED **");
    end else begin
      $display("** square_wave_sound_channel: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** square_wave_sound_channel: FAILED **");
    $finish;
  end

endmodule

/* square_wave_sound_channel.f */
+incdir+rtl/core
rtl/core/sqw_pkg.sv
rtl/core/sqw_core.sv
rtl/core/square_wave_sound_channel.sv
test/tb_top.sv
